// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL (bdc_merge)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bdc_pkg.sv =====
`timescale 1ns / 1ps
package bdc_pkg;

   localparam int unsigned MASK_W     = 3;
   localparam int unsigned NSLOT      = 4;
   localparam int unsigned MAX_EVENTS = 6;
   localparam int unsigned CNT_W      = 3;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_LONG     = 2'd1;
   localparam logic [1:0] CSR_ENABLE   = 2'd2;

   localparam logic [1:0] SLOT_PRESS   = 2'd0;
   localparam logic [1:0] SLOT_RELEASE = 2'd1;
   localparam logic [1:0] SLOT_SHORT   = 2'd2;
   localparam logic [1:0] SLOT_LONG    = 2'd3;

   typedef enum logic [2:0] {
      EV_STATUS  = 3'd0,
      EV_PRESS   = 3'd1,
      EV_RELEASE = 3'd2,
      EV_SHORT   = 3'd3,
      EV_LONG    = 3'd4
   } event_code_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic edge_hit;
      logic tick_go;
      logic level;
   } lane_ctl_type;

   typedef struct packed {
      logic [7:0]  deb_ticks;
      logic [15:0] long_ticks;
   } lane_cfg_type;

   typedef struct packed {
      logic             pressed;
      logic             keep;
      logic [NSLOT-1:0] events;
   } lane_stat_type;

   function automatic event_code_type slot_code(input logic [1:0] slot);
      event_code_type code;
      unique case (slot)
         SLOT_PRESS:   code = EV_PRESS;
         SLOT_RELEASE: code = EV_RELEASE;
         SLOT_SHORT:   code = EV_SHORT;
         SLOT_LONG:    code = EV_LONG;
         default:      code = EV_STATUS;
      endcase
      return code;
   endfunction

endpackage

// ===== src/bdc_req_if.sv =====
`timescale 1ns / 1ps
interface bdc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [1:0] button;
   logic [2:0] levels;

   modport source (output valid, op, button, levels, input ready);
   modport sink (input valid, op, button, levels, output ready);
endinterface

// ===== src/bdc_rsp_if.sv =====
`timescale 1ns / 1ps
interface bdc_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              button_id;
   bdc_pkg::event_code_type event_code;
   logic [2:0]              pressed_mask;
   logic                    last;

   modport source (output valid, button_id, event_code, pressed_mask, last, input ready);
   modport sink (input valid, button_id, event_code, pressed_mask, last, output ready);
endinterface

// ===== src/bdc_csr_if.sv =====
`timescale 1ns / 1ps
interface bdc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bdc_lane.sv =====
`timescale 1ns / 1ps
module bdc_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bdc_pkg::lane_ctl_type  ctl,
   input  bdc_pkg::lane_cfg_type  cfg,
   output bdc_pkg::lane_stat_type stat
);
   import bdc_pkg::*;

   logic [7:0]       dc_ff, dc_in, dc_inc;
   logic [15:0]      hold_ff, hold_in, hold_inc;
   logic             busy_ff, busy_in;
   logic             pressed_ff, pressed_in;
   logic             lf_ff, lf_in;
   logic             keep;
   logic [NSLOT-1:0] ev;
   logic [15:0]      hold_sel;

   assign dc_inc = dc_ff + 8'd1;

   always_comb begin
      busy_in    = busy_ff;
      dc_in      = dc_ff;
      pressed_in = pressed_ff;
      lf_in      = lf_ff;
      hold_sel   = hold_ff;
      ev         = '0;
      keep       = 1'b0;
      if (busy_ff) begin
         if (dc_inc >= cfg.deb_ticks) begin
            if (ctl.level && !pressed_ff) begin
               pressed_in     = 1'b1;
               ev[SLOT_PRESS] = 1'b1;
               hold_sel       = '0;
            end else if (!ctl.level && pressed_ff) begin
               pressed_in       = 1'b0;
               ev[SLOT_RELEASE] = 1'b1;
               ev[SLOT_SHORT]   = !lf_ff;
               lf_in            = 1'b0;
            end
            busy_in = 1'b0;
            dc_in   = '0;
         end else begin
            dc_in = dc_inc;
            keep  = 1'b1;
         end
      end
      hold_inc = hold_sel + 16'd1;
      hold_in  = hold_sel;
      if (pressed_in && !lf_in) begin
         hold_in = hold_inc;
         if (hold_inc >= cfg.long_ticks) begin
            lf_in         = 1'b1;
            ev[SLOT_LONG] = 1'b1;
         end
         keep = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff      <= '0;
         hold_ff    <= '0;
         busy_ff    <= 1'b0;
         pressed_ff <= 1'b0;
         lf_ff      <= 1'b0;
      end else if (step) begin
         if (ctl.edge_hit) begin
            dc_ff   <= '0;
            busy_ff <= 1'b1;
         end else if (ctl.tick_go) begin
            dc_ff      <= dc_in;
            hold_ff    <= hold_in;
            busy_ff    <= busy_in;
            pressed_ff <= pressed_in;
            lf_ff      <= lf_in;
         end
      end
   end

   assign stat.pressed = pressed_ff;
   assign stat.keep    = keep & ctl.tick_go;
   assign stat.events  = ev & {NSLOT{ctl.tick_go}};

endmodule

// ===== src/bdc_merge.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdc_merge #(
   parameter int unsigned NUM_BUTTONS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   event_enable,
   input  bdc_pkg::lane_stat_type lane_stat [NUM_BUTTONS],
   output logic                   idle,
   bdc_rsp_if.source              rsp_ch
);
   import bdc_pkg::*;

   localparam int unsigned PW = NUM_BUTTONS * NSLOT;

   state_type      state_ff, state_in;
   logic [PW-1:0]  pend_ff, pend_load, sel;
   logic [CNT_W-1:0] cnt_ff;
   logic           ev_go, out_free, load_ev, load_st;
   logic [1:0]     ev_id;
   event_code_type ev_code;
   logic [MASK_W-1:0] mask;

   logic           valid_ff;
   logic [1:0]     id_ff;
   event_code_type code_ff;
   logic [MASK_W-1:0] mask_ff;
   logic           last_ff;

   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (b < NUM_BUTTONS) begin : g_on
         assign mask[b] = lane_stat[b].pressed;
      end else begin : g_off
         assign mask[b] = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         for (int s = 0; s < NSLOT; s++) begin
            pend_load[i*NSLOT+s] = event_enable & lane_stat[i].events[s];
         end
      end
   end

   // lowest set bit: lane order first, then slot order within a lane
   assign sel = pend_ff & (~pend_ff + PW'(1));

   always_comb begin
      ev_id   = '0;
      ev_code = EV_STATUS;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         for (int s = 0; s < NSLOT; s++) begin
            if (sel[i*NSLOT+s]) begin
               ev_id   = 2'(i);
               ev_code = slot_code(2'(s));
            end
         end
      end
   end

   assign out_free = !valid_ff || rsp_ch.ready;
   assign ev_go    = (|pend_ff) && (cnt_ff < CNT_W'(MAX_EVENTS));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (step) state_in = ST_DRAIN;
         ST_DRAIN: if (out_free && !ev_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idle    = 1'b0;
      load_ev = 1'b0;
      load_st = 1'b0;
      unique case (state_ff)
         ST_IDLE:  idle = 1'b1;
         ST_DRAIN: begin
            load_ev = out_free && ev_go;
            load_st = out_free && !ev_go;
         end
         default:  idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (step) begin
            pend_ff <= pend_load;
            cnt_ff  <= '0;
         end else if (load_ev) begin
            pend_ff <= pend_ff & ~sel;
            cnt_ff  <= cnt_ff + CNT_W'(1);
         end else if (load_st) begin
            pend_ff <= '0;
         end
         if (load_ev || load_st) begin
            valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ev || load_st) begin
         id_ff   <= load_ev ? ev_id : 2'd0;
         code_ff <= load_ev ? ev_code : EV_STATUS;
         mask_ff <= mask;
         last_ff <= load_st;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.button_id    = id_ff;
   assign rsp_ch.event_code   = code_ff;
   assign rsp_ch.pressed_mask = mask_ff;
   assign rsp_ch.last         = last_ff;

   `ASSERT_IMPLIES(a_idle_empty, clock, reset, state_ff == ST_IDLE, pend_ff == '0, "pending while idle")
   `ASSERT_NEXT(a_step_drain, clock, reset, step, state_ff == ST_DRAIN, "no drain after transfer")
   `ASSERT_NEXT(a_status_last, clock, reset, load_st, rsp_ch.valid && rsp_ch.last, "status not last")

endmodule

// ===== src/button_debounce_click_detector.sv =====
`timescale 1ns / 1ps
// The first result enters the output register once the merge stage, loaded
// at the input transfer, drains. Each item gives E events (at most 6), then a
// status result, one a cycle unless the output stalls; items wait for idle.
// Reset: synchronous, clears all button state and the scanner, restores
// debounce 4, long press 100 and events off; no clearing pass.
module button_debounce_click_detector #(
   parameter int unsigned NUM_BUTTONS = 3
) (
   input  logic      clock,
   input  logic      reset,
   bdc_req_if.sink   req_ch,
   bdc_rsp_if.source rsp_ch,
   bdc_csr_if.sink   csr_ch
);
   import bdc_pkg::*;

   logic [7:0]  deb_ff;
   logic [15:0] lpt_ff;
   logic        en_ff;
   logic        scan_ff, scan_in;
   logic        idle, step;

   lane_cfg_type  cfg;
   lane_ctl_type  lane_ctl  [NUM_BUTTONS];
   lane_stat_type lane_stat [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] edge_vec, keep_vec;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff <= 8'd4;
         lpt_ff <= 16'd100;
         en_ff  <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DEBOUNCE: deb_ff <= csr_ch.data[7:0];
            CSR_LONG:     lpt_ff <= csr_ch.data;
            CSR_ENABLE:   en_ff  <= csr_ch.data[0];
            default:      en_ff  <= en_ff;
         endcase
      end
   end

   assign cfg.deb_ticks  = deb_ff;
   assign cfg.long_ticks = lpt_ff;

   assign req_ch.ready = idle;
   assign step         = req_ch.valid && idle;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      if (g < 4) begin : g_edge
         assign lane_ctl[g].edge_hit = (req_ch.op == OP_EDGE) && (req_ch.button == 2'(g));
      end else begin : g_noedge
         assign lane_ctl[g].edge_hit = 1'b0;
      end
      if (g < 3) begin : g_lvl
         assign lane_ctl[g].level = req_ch.levels[g];
      end else begin : g_nolvl
         assign lane_ctl[g].level = 1'b0;
      end
      assign lane_ctl[g].tick_go = (req_ch.op == OP_TICK) && scan_ff;
      assign edge_vec[g]         = lane_ctl[g].edge_hit;
      assign keep_vec[g]         = lane_stat[g].keep;

      bdc_lane u_lane (
         .clock (clock),
         .reset (reset),
         .step  (step),
         .ctl   (lane_ctl[g]),
         .cfg   (cfg),
         .stat  (lane_stat[g])
      );
   end

   always_comb begin
      scan_in = scan_ff;
      if (req_ch.op == OP_EDGE) begin
         if (|edge_vec) scan_in = 1'b1;
      end else if (scan_ff) begin
         scan_in = |keep_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0;
      end else if (step) begin
         scan_ff <= scan_in;
      end
   end

   bdc_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .event_enable (en_ff),
      .lane_stat    (lane_stat),
      .idle         (idle),
      .rsp_ch       (rsp_ch)
   );

endmodule

// ===== tb/sv/tb_button_debounce_click_detector.sv =====
`timescale 1ns / 1ps
module tb_button_debounce_click_detector;
   import bdc_pkg::*;

   localparam int unsigned NUM_BTN     = 3;
   localparam int unsigned STUCK_LIMIT = 3000;
   localparam int unsigned SETTLE      = 12;
   localparam logic [1:0]  CSR_SPARE   = 2'd3;
   localparam logic [1:0]  BTN_NONE    = 2'd3;

   typedef struct packed {
      logic [1:0]     button_id;
      event_code_type code;
      logic [2:0]     mask;
      logic           last;
   } click_result_type;

   logic clock;
   logic reset;

   bdc_req_if req_ch ();
   bdc_rsp_if rsp_ch ();
   bdc_csr_if csr_ch ();

   button_debounce_click_detector #(
      .NUM_BUTTONS(NUM_BTN)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // qualifier state as seen from outside
   logic [7:0]  deb_limit;
   logic [15:0] long_limit;
   logic        ev_on;
   logic [7:0]  deb_cnt    [NUM_BTN];
   logic [15:0] hold_ticks [NUM_BTN];
   logic        deb_busy   [NUM_BTN];
   logic        pressed    [NUM_BTN];
   logic        long_done  [NUM_BTN];
   logic        scanning;

   click_result_type fresh_events[$];
   click_result_type due_results[$];

   bit          gaps_on;
   int unsigned rsp_hold_off;
   logic [2:0]  truth_levels;
   int unsigned stuck_cycles;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned writes_done;
   int unsigned events_seen[5];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic void clear_buttons();
      deb_limit  = 8'd4;
      long_limit = 16'd100;
      ev_on      = 1'b0;
      scanning   = 1'b0;
      for (int i = 0; i < NUM_BTN; i++) begin
         deb_cnt[i]    = '0;
         hold_ticks[i] = '0;
         deb_busy[i]   = 1'b0;
         pressed[i]    = 1'b0;
         long_done[i]  = 1'b0;
      end
   endfunction

   function automatic void note_event(input int unsigned id, input event_code_type code);
      click_result_type ev;
      if (!ev_on || fresh_events.size() >= MAX_EVENTS)
         return;
      ev.button_id = id[1:0];
      ev.code      = code;
      ev.mask      = '0;
      ev.last      = 1'b0;
      fresh_events.push_back(ev);
   endfunction

   function automatic void qualify_item(input logic op, input logic [1:0] btn,
                                        input logic [2:0] lv);
      logic             any;
      logic [2:0]       mask;
      click_result_type r;
      fresh_events.delete();
      any = 1'b0;
      if (op == OP_EDGE) begin
         if (btn < NUM_BTN) begin
            deb_cnt[btn]  = '0;
            deb_busy[btn] = 1'b1;
            scanning      = 1'b1;
         end
      end else if (scanning) begin
         for (int i = 0; i < NUM_BTN; i++) begin
            if (deb_busy[i]) begin
               deb_cnt[i] = deb_cnt[i] + 8'd1;
               if (deb_cnt[i] >= deb_limit) begin
                  if (lv[i] && !pressed[i]) begin
                     pressed[i] = 1'b1;
                     note_event(i, EV_PRESS);
                     hold_ticks[i] = '0;
                  end else if (!lv[i] && pressed[i]) begin
                     pressed[i] = 1'b0;
                     note_event(i, EV_RELEASE);
                     if (!long_done[i])
                        note_event(i, EV_SHORT);
                     long_done[i] = 1'b0;
                  end
                  deb_busy[i] = 1'b0;
                  deb_cnt[i]  = '0;
               end else begin
                  any = 1'b1;
               end
            end
            if (pressed[i] && !long_done[i]) begin
               hold_ticks[i] = hold_ticks[i] + 16'd1;
               if (hold_ticks[i] >= long_limit) begin
                  long_done[i] = 1'b1;
                  note_event(i, EV_LONG);
               end
               any = 1'b1;
            end
         end
         scanning = any;
      end
      mask = '0;
      for (int i = 0; i < NUM_BTN; i++)
         mask[i] = pressed[i];
      foreach (fresh_events[k]) begin
         r      = fresh_events[k];
         r.mask = mask;
         due_results.push_back(r);
      end
      r.button_id = '0;
      r.code      = EV_STATUS;
      r.mask      = mask;
      r.last      = 1'b1;
      due_results.push_back(r);
   endfunction

   // valid stays high across back-to-back transfers; a gap lowers it
   task automatic send_item(input logic op, input logic [1:0] btn, input logic [2:0] lv);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.button <= btn;
      req_ch.levels <= lv;
      do @(posedge clock); while (!req_ch.ready);
      qualify_item(op, btn, lv);
      items_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_DEBOUNCE: deb_limit  = value[7:0];
         CSR_LONG:     long_limit = value;
         CSR_ENABLE:   ev_on      = value[0];
         default:      ;
      endcase
      writes_done++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] deb, input logic [15:0] hold,
                             input logic en, input bit spare);
      wait_idle();
      write_reg(CSR_DEBOUNCE, {8'($urandom), deb});
      write_reg(CSR_LONG, hold);
      write_reg(CSR_ENABLE, {15'($urandom), en});
      if (spare)
         write_reg(CSR_SPARE, 16'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   // mostly clean edge-then-settle sequences, some bounce and raw noise
   task automatic random_stream(input int unsigned count, input int unsigned noise_pct);
      int unsigned r;
      int unsigned b;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      3'($urandom_range(0, 7)));
         end else if (r < noise_pct + 15) begin
            b = $urandom_range(0, NUM_BTN - 1);
            if ($urandom_range(0, 9) != 0)
               truth_levels[b] = ~truth_levels[b];
            send_item(OP_EDGE, b[1:0], 3'($urandom_range(0, 7)));
         end else begin
            send_item(OP_TICK, 2'($urandom_range(0, 3)), truth_levels);
         end
      end
   endtask

   task automatic test_after_reset();
      send_item(OP_TICK, 2'd0, 3'd7);
      send_item(OP_EDGE, BTN_NONE, 3'd0);
      send_item(OP_TICK, 2'd0, 3'd7);
      send_item(OP_EDGE, 2'd1, 3'd0);
      repeat (5) send_item(OP_TICK, 2'd0, 3'd2);
   endtask

   task automatic test_click_events();
      set_config(8'd1, 16'd3, 1'b1, 1'b1);
      send_item(OP_EDGE, 2'd0, 3'd0);
      send_item(OP_TICK, 2'd0, 3'd1);
      send_item(OP_TICK, 2'd0, 3'd1);
      send_item(OP_TICK, 2'd0, 3'd1);
      send_item(OP_EDGE, 2'd0, 3'd0);
      send_item(OP_TICK, 2'd0, 3'd0);
      send_item(OP_EDGE, 2'd1, 3'd0);
      send_item(OP_TICK, 2'd0, 3'd2);
      send_item(OP_EDGE, 2'd1, 3'd0);
      send_item(OP_TICK, 2'd0, 3'd0);
      send_item(OP_EDGE, 2'd2, 3'd7);
      send_item(OP_TICK, 2'd3, 3'd4);
      send_item(OP_TICK, 2'd3, 3'd4);
      send_item(OP_TICK, 2'd3, 3'd4);
      send_item(OP_EDGE, 2'd2, 3'd7);
      send_item(OP_TICK, 2'd3, 3'd0);
   endtask

   // zero thresholds: every button presses and fires long on one tick
   task automatic test_zero_thresholds();
      set_config(8'd0, 16'd0, 1'b1, 1'b0);
      for (int i = 0; i < NUM_BTN; i++)
         send_item(OP_EDGE, i[1:0], 3'd0);
      send_item(OP_TICK, 2'd0, 3'd7);
      for (int i = 0; i < NUM_BTN; i++)
         send_item(OP_EDGE, i[1:0], 3'd7);
      send_item(OP_TICK, 2'd0, 3'd0);
      truth_levels = 3'd0;
   endtask

   task automatic test_random_settings();
      set_config(8'd1, 16'd4, 1'b1, 1'b0);
      random_stream(90, 15);
      set_config(8'd2, 16'd1, 1'b1, 1'b0);
      random_stream(70, 15);
      set_config(8'd3, 16'd12, 1'b0, 1'b0);
      random_stream(30, 20);
      set_config(8'd255, 16'd65535, 1'b1, 1'b0);
      random_stream(15, 30);
   endtask

   task automatic test_backpressure();
      set_config(8'd1, 16'd2, 1'b1, 1'b0);
      rsp_hold_off = 150;
      random_stream(40, 10);
   endtask

   task automatic test_full_rate();
      set_config(8'd1, 16'd3, 1'b1, 1'b0);
      gaps_on = 1'b0;
      random_stream(50, 10);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         int unsigned stall_left;
         @(posedge clock);
         if (rsp_hold_off != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_off--;
         end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : p_check
      click_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (int'(rsp_ch.event_code) < 5)
            events_seen[int'(rsp_ch.event_code)]++;
         if (due_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = due_results.pop_front();
            if (rsp_ch.button_id !== want.button_id)
               report_mismatch($sformatf("button_id got %0d want %0d",
                                         rsp_ch.button_id, want.button_id));
            if (rsp_ch.event_code !== want.code)
               report_mismatch($sformatf("event_code got %0d want %0d",
                                         rsp_ch.event_code, want.code));
            if (rsp_ch.pressed_mask !== want.mask)
               report_mismatch($sformatf("pressed_mask got %b want %b",
                                         rsp_ch.pressed_mask, want.mask));
            if (rsp_ch.last !== want.last)
               report_mismatch($sformatf("last got %b want %b", rsp_ch.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.op     <= OP_EDGE;
      req_ch.button <= '0;
      req_ch.levels <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= CSR_DEBOUNCE;
      csr_ch.data   <= '0;
      reset         <= 1'b1;
      gaps_on       = 1'b1;
      rsp_hold_off  = 0;
      truth_levels  = 3'd0;
      stuck_cycles  = 0;
      clear_buttons();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_click_events();
      test_zero_thresholds();
      test_random_settings();
      test_backpressure();
      test_full_rate();
      wait_idle();

      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      $display("run: %0d items, %0d results checked, %0d register writes, %0d mismatches",
               items_sent, results_checked, writes_done, error_count);
      $display("events: press %0d, release %0d, short %0d, long %0d",
               events_seen[1], events_seen[2], events_seen[3], events_seen[4]);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bdc_pkg.sv
src/bdc_req_if.sv
src/bdc_rsp_if.sv
src/bdc_csr_if.sv
src/bdc_lane.sv
src/bdc_merge.sv
src/button_debounce_click_detector.sv
tb/sv/tb_button_debounce_click_detector.sv
